/* rtl/bsol_pkg.sv */
// ----------------------------------------------------------------------------
// bsol_pkg
// Word layouts and operation/status codes for the bitmap slot ordered list.
// ----------------------------------------------------------------------------
package bsol_pkg;

  localparam logic [1:0] KIND_INSERT    = 2'd0;
  localparam logic [1:0] KIND_DEL_VALUE = 2'd1;
  localparam logic [1:0] KIND_DEL_INDEX = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  typedef struct packed {
    logic        [1:0]  kind;
    logic signed [31:0] value;
    logic        [2:0]  position;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] slot;
    logic [3:0] removed;
    logic [3:0] count;
    logic [7:0] occupancy;
  } out_word_t;

endpackage

/* rtl/bitmap_slot_ordered_list.sv */
// ----------------------------------------------------------------------------
// bitmap_slot_ordered_list
// One node of an unrolled list: slot storage, occupancy bitmap and a
// newest-first linked order, with insert, delete by value and delete by index.
// ----------------------------------------------------------------------------
// Works on one word at a time; in_ready is high only while idle, and a finished
// result waits in the output register while the next word is taken. An insert,
// a rejected word or an unused kind goes straight from idle to the done state.
// Delete by value visits every live entry and delete by index steps past
// position entries: the walk follows the order one entry per cycle through the
// registered read port of the link and value RAMs, and the compare against the
// key is the single unit reused at each step. Values are held in their low
// VALUE_BITS bits after sign extension of the 32-bit input.
// ----------------------------------------------------------------------------
module bitmap_slot_ordered_list #(
  parameter int SLOTS      = 8,
  parameter int VALUE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bsol_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bsol_pkg::out_word_t out_data
);

  import bsol_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CMP_W = CNT_W + 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK_VAL,
    ST_WALK_IDX,
    ST_DONE
  } state_t;

  state_t state;

  logic [SLOTS-1:0]      occupied;
  logic [IDX_W-1:0]      front_slot;
  logic [CNT_W-1:0]      count;
  logic [IDX_W-1:0]      cur;
  logic [IDX_W-1:0]      prev;
  logic                  has_prev;
  logic [CNT_W-1:0]      remaining;
  logic [2:0]            steps;
  logic [VALUE_BITS-1:0] key;
  logic [1:0]            res_status;
  logic [IDX_W-1:0]      res_slot;
  logic [CNT_W-1:0]      removed;

  logic [VALUE_BITS-1:0] value_rdata;
  logic [IDX_W-1:0]      link_rdata;
  logic                  value_we;
  logic                  link_we;
  logic [IDX_W-1:0]      link_waddr;
  logic [IDX_W-1:0]      link_wdata;
  logic [IDX_W-1:0]      raddr;

  logic                  accept;
  logic                  full;
  logic [IDX_W-1:0]      free_slot;
  logic [63:0]           value_ext;
  logic [VALUE_BITS-1:0] in_key;
  logic                  match;
  logic                  range_bad;

  function automatic logic [IDX_W-1:0] first_zero(input logic [SLOTS-1:0] bits);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!bits[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign full      = &occupied;
  assign free_slot = first_zero(occupied);
  assign value_ext = {{32{in_data.value[31]}}, in_data.value};
  assign in_key    = value_ext[VALUE_BITS-1:0];
  assign match     = (value_rdata == key);
  assign range_bad = CMP_W'(in_data.position) >= CMP_W'(count);
  assign raddr     = (state == ST_IDLE) ? front_slot : link_rdata;

  // ram write ports
  always_comb begin
    value_we   = 1'b0;
    link_we    = 1'b0;
    link_waddr = prev;
    link_wdata = link_rdata;
    unique case (state)
      ST_IDLE: begin
        if (accept && in_data.kind == KIND_INSERT && !full) begin
          value_we   = 1'b1;
          link_we    = 1'b1;
          link_waddr = free_slot;
          link_wdata = front_slot;
        end
      end
      ST_WALK_VAL: begin
        link_we = match && has_prev;
      end
      ST_WALK_IDX: begin
        link_we = (steps == 3'd0) && has_prev;
      end
      ST_DONE: begin
        link_we = 1'b0;
      end
      default: begin
        link_we = 1'b0;
      end
    endcase
  end

  bsol_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (SLOTS)
  ) u_value_ram (
    .clk   (clk),
    .we    (value_we),
    .waddr (free_slot),
    .wdata (in_key),
    .raddr (raddr),
    .rdata (value_rdata)
  );

  bsol_ram #(
    .WIDTH (IDX_W),
    .DEPTH (SLOTS)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (raddr),
    .rdata (link_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      occupied   <= '0;
      front_slot <= '0;
      count      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cur        <= front_slot;
            has_prev   <= 1'b0;
            key        <= in_key;
            remaining  <= count;
            steps      <= in_data.position;
            removed    <= '0;
            unique case (in_data.kind)
              KIND_INSERT: begin
                state <= ST_DONE;
                if (full) begin
                  res_status <= STATUS_FULL;
                  res_slot   <= '0;
                end else begin
                  res_status          <= STATUS_OK;
                  occupied[free_slot] <= 1'b1;
                  front_slot          <= free_slot;
                  count               <= count + CNT_W'(1);
                  res_slot            <= free_slot;
                end
              end
              KIND_DEL_VALUE: begin
                res_status <= STATUS_OK;
                res_slot   <= '0;
                state      <= (count != '0) ? ST_WALK_VAL : ST_DONE;
              end
              KIND_DEL_INDEX: begin
                res_slot <= '0;
                if (range_bad) begin
                  res_status <= STATUS_RANGE;
                  state      <= ST_DONE;
                end else begin
                  res_status <= STATUS_OK;
                  state      <= ST_WALK_IDX;
                end
              end
              default: begin
                res_status <= STATUS_OK;
                res_slot   <= '0;
                state      <= ST_DONE;
              end
            endcase
          end
        end
        ST_WALK_VAL: begin
          if (match) begin
            if (!has_prev) begin
              front_slot <= link_rdata;
            end
            occupied[cur] <= 1'b0;
            count         <= count - CNT_W'(1);
            removed       <= removed + CNT_W'(1);
          end else begin
            prev     <= cur;
            has_prev <= 1'b1;
          end
          cur       <= link_rdata;
          remaining <= remaining - CNT_W'(1);
          if (remaining == CNT_W'(1)) begin
            state <= ST_DONE;
          end
        end
        ST_WALK_IDX: begin
          if (steps == 3'd0) begin
            if (!has_prev) begin
              front_slot <= link_rdata;
            end
            occupied[cur] <= 1'b0;
            count         <= count - CNT_W'(1);
            removed       <= CNT_W'(1);
            res_slot      <= cur;
            state         <= ST_DONE;
          end else begin
            prev     <= cur;
            has_prev <= 1'b1;
            cur      <= link_rdata;
            steps    <= steps - 3'd1;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid          <= 1'b1;
            out_data.status    <= res_status;
            out_data.slot      <= 3'(res_slot);
            out_data.removed   <= 4'(removed);
            out_data.count     <= 4'(count);
            out_data.occupancy <= 8'(occupied);
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // bitmap and live count track each other
  a_count_matches_bitmap: assert property (@(posedge clk) disable iff (rst)
    $countones(occupied) == int'(count))
    else $error("live count differs from occupancy bitmap");

  // head of the order is a live slot whenever the list is not empty
  a_front_live: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && count != '0) |-> occupied[front_slot])
    else $error("front slot is not occupied");

  // only a successful operation frees entries
  a_removed_ok_only: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status == STATUS_OK || out_data.removed == 4'd0))
    else $error("entries freed on a rejected operation");

  // an accepted insert into a non-full node grows the count by one
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.kind == KIND_INSERT && !full) |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not add an entry");

endmodule

/* rtl/bsol_ram.sv */
// ----------------------------------------------------------------------------
// bsol_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
